FILE: design/bta_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bta_pkg
// shared types and constants of the bus telegram assembler
// ---------------------------------------------------------------------------
package bta_pkg;

  localparam logic [3:0] STD_LEN   = 4'd7;
  localparam logic [3:0] EXT_LEN   = 4'd11;
  localparam logic [7:0] HI_MASK   = 8'hF0;
  localparam logic [7:0] HI_EXT_D  = 8'hD0;
  localparam logic [7:0] HI_EXT_E  = 8'hE0;
  localparam logic [7:0] START_RST = 8'hA8;
  localparam logic [7:0] ACK_RST   = 8'hA5;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_ACK   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_STD = 2'd1,
    KIND_EXT = 2'd2,
    KIND_BAD = 2'd3
  } frame_kind_t;

  typedef struct packed {
    logic       fire;
    logic [7:0] rx_byte;
  } step_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [31:0] front;
    logic [31:0] back;
    logic [7:0]  check;
    logic [7:0]  closing;
  } result_t;

endpackage

FILE: design/bta_in_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bta_in_stage
// input register for received words, hands one word per cycle to the core while the output stage advances
// ---------------------------------------------------------------------------
module bta_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_rx_byte,
  input  logic          adv,
  output bta_pkg::step_t step
);
  import bta_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign in_stall = vld_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign step.fire    = vld_r && adv;
  assign step.rx_byte = byte_r;

endmodule

FILE: design/bta_frame_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bta_frame_core
// marker registers, frame state and per-word frame decode
// ---------------------------------------------------------------------------
module bta_frame_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_wdata,
  input  bta_pkg::step_t   step,
  output logic             res_valid,
  output bta_pkg::result_t res
);
  import bta_pkg::*;

  logic [7:0] start_r;
  logic [7:0] ack_r;
  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;
  logic [3:0] len_r;
  logic [3:0] len_nxt;
  logic [7:0] xor_r;
  logic [7:0] xor_nxt;
  logic [7:0] fb_r [1:9];

  logic [7:0] b;
  logic [7:0] hi;
  logic       ext;
  logic       store;

  assign b  = step.rx_byte;
  assign hi = b & HI_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      ack_r   <= ACK_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_START) begin
        start_r <= cfg_wdata;
      end else begin
        ack_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    store     = 1'b0;
    res_valid = 1'b0;
    ext       = (len_r == EXT_LEN);
    res.kind    = KIND_ACK;
    res.front   = '0;
    res.back    = '0;
    res.check   = '0;
    res.closing = '0;
    if (step.fire) begin
      if (cnt_r == 4'd0) begin
        if (b == ack_r) begin
          res_valid = 1'b1;
        end else if (b == start_r) begin
          cnt_nxt = 4'd1;
          len_nxt = 4'd0;
          xor_nxt = 8'd0;
        end
      end else if (b == start_r) begin
        cnt_nxt = 4'd1;
        len_nxt = 4'd0;
        xor_nxt = 8'd0;
      end else if (cnt_r >= EXT_LEN) begin
        cnt_nxt = 4'd0;
        len_nxt = 4'd0;
        xor_nxt = 8'd0;
      end else begin
        store   = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd1) begin
          len_nxt = (hi == HI_EXT_D || hi == HI_EXT_E) ? EXT_LEN : STD_LEN;
          xor_nxt = b;
        end else if (({1'b0, cnt_r} + 5'd3) <= {1'b0, len_r}) begin
          xor_nxt = xor_r ^ b;
        end
        // frame complete on its closing word
        if (cnt_r != 4'd1 && (cnt_r + 4'd1) == len_r) begin
          res_valid   = 1'b1;
          res.front   = {fb_r[1], fb_r[2], fb_r[3], fb_r[4]};
          res.back    = ext ? {fb_r[5], fb_r[6], fb_r[7], fb_r[8]} : 32'd0;
          res.check   = ext ? fb_r[9] : fb_r[5];
          res.closing = b;
          if (res.check == xor_r) begin
            res.kind = ext ? KIND_EXT : KIND_STD;
          end else begin
            res.kind = KIND_BAD;
          end
          cnt_nxt = 4'd0;
          len_nxt = 4'd0;
          xor_nxt = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      len_r <= 4'd0;
      xor_r <= 8'd0;
    end else begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
      xor_r <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= 9; i++) begin
      if (store && cnt_r == 4'(i)) begin
        fb_r[i] <= b;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= EXT_LEN)
    else $error("frame count beyond extended length");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    len_r == 4'd0 || len_r == STD_LEN || len_r == EXT_LEN)
    else $error("illegal frame length");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 4'd0 |-> (len_r == 4'd0 && xor_r == 8'd0))
    else $error("idle with stale frame state");

  a_len_known: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= 4'd2 |-> len_r != 4'd0)
    else $error("frame length unknown after first payload word");

  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= 4'd2 |-> cnt_r < len_r)
    else $error("frame count reached length without completing");

endmodule

FILE: design/bta_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bta_out_stage
// result register toward the output channel
// ---------------------------------------------------------------------------
module bta_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  bta_pkg::result_t res,
  output logic             adv,
  output logic             out_valid,
  input  logic             out_stall,
  output bta_pkg::result_t out_res
);
  import bta_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign adv = !vld_r || !out_stall;

  always_comb begin
    if (adv) begin
      vld_nxt = res_valid;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

FILE: design/bus_telegram_assembler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bus_telegram_assembler
// rebuilds acknowledge and telegram frames from received bus words
// ---------------------------------------------------------------------------
// path: the word that completes a result waits in the input register, is decoded
// combinationally and its result is captured in the result register
// throughput: one word per cycle unless a stalled result blocks the output,
// set by the single decode step between the input and result registers
// reset: synchronous, clears frame state and valid flags, markers return to
// 0xA8 (start) and 0xA5 (acknowledge)
module bus_telegram_assembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_kind,
  output logic [31:0] out_payload_front,
  output logic [31:0] out_payload_back,
  output logic [7:0]  out_check_byte,
  output logic [7:0]  out_closing_byte
);
  import bta_pkg::*;

  step_t   step;
  logic    adv;
  logic    res_valid;
  result_t res;
  result_t out_res;

  bta_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .adv       (adv),
    .step      (step)
  );

  bta_frame_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .step     (step),
    .res_valid(res_valid),
    .res      (res)
  );

  bta_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .adv      (adv),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_frame_kind    = out_res.kind;
  assign out_payload_front = out_res.front;
  assign out_payload_back  = out_res.back;
  assign out_check_byte    = out_res.check;
  assign out_closing_byte  = out_res.closing;

endmodule
